@@ hdl/pttx_pkg.sv @@
// ----------------------------------------------------------------------------
// pttx_pkg
// Shared words, codeword encoder and controller/datapath interface types for
// the alphanumeric page encoder.
// ----------------------------------------------------------------------------
package pttx_pkg;

    localparam logic [31:0] SYNC_WORD     = 32'h7CD2_15D8;
    localparam logic [31:0] IDLE_WORD     = 32'h7A89_C197;
    localparam logic [31:0] PREAMBLE_WORD = 32'h5555_5555;
    localparam logic [10:0] BCH_GEN       = 11'h769;

    localparam int DATA_BITS  = 21;
    localparam int CHECK_BITS = 10;
    localparam int WORD_BITS  = 20;
    localparam int CHAR_BITS  = 7;

    // configuration register indexes
    localparam logic CFG_PREAMBLE = 1'b0;
    localparam logic CFG_FUNCTION = 1'b1;

    // check bits contributed by each single data bit (the code is linear)
    function automatic logic [DATA_BITS-1:0][CHECK_BITS-1:0] f_bch_tbl();
        logic [DATA_BITS-1:0][CHECK_BITS-1:0] tbl;
        logic [30:0]                          r;
        for (int i = 0; i < DATA_BITS; i++) begin
            r = 31'd1 << (i + CHECK_BITS);
            for (int b = 30; b >= CHECK_BITS; b--) begin
                if (r[b]) begin
                    r = r ^ (31'(BCH_GEN) << (b - CHECK_BITS));
                end
            end
            tbl[i] = r[CHECK_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam logic [DATA_BITS-1:0][CHECK_BITS-1:0] BCH_TBL = f_bch_tbl();

    // 21 data bits, 10 check bits, even parity
    function automatic logic [31:0] f_codeword(input logic [DATA_BITS-1:0] data);
        logic [CHECK_BITS-1:0] chk;
        logic [30:0]           full;
        chk = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            if (data[i]) begin
                chk = chk ^ BCH_TBL[i];
            end
        end
        full = {data, chk};
        return {full, ^full};
    endfunction

    typedef enum logic [2:0] {
        W_PREAMBLE,
        W_SYNC,
        W_IDLE,
        W_ADDR,
        W_MSG,
        W_PAD
    } t_wsel;

    typedef struct packed {
        logic  take;       // latch the input beat
        logic  add;        // append the character bits
        logic  emit;       // load the output register
        t_wsel wsel;
        logic  last_word;
        logic  pos_set;    // batch slot after the address word
        logic  pos_inc;
        logic  msg_clr;
    } t_cmd;

    typedef struct packed {
        logic       first;
        logic       last;
        logic [2:0] frame;
        logic       in_msg;
        logic       word_full;   // the pending character completes a word
        logic       pad_needed;
        logic       pos_last;
        logic       out_free;
        logic [5:0] preamble_words;
    } t_stat;

endpackage

@@ hdl/pttx_dp.sv @@
// ----------------------------------------------------------------------------
// pttx_dp
// Datapath: input latch, configuration, bit packer, batch slot counter,
// codeword encoder and output register.
// ----------------------------------------------------------------------------
module pttx_dp
    import pttx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_wdata,
    input  logic [6:0]  i_char_code,
    input  logic        i_first_char,
    input  logic        i_last_char,
    input  logic [20:0] i_pager_address,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_codeword,
    output logic        o_last_word
);

    logic [6:0]  r_char;
    logic        r_first;
    logic        r_last;
    logic [20:0] r_addr;
    logic [5:0]  r_pw;
    logic [1:0]  r_fb;
    logic [19:0] r_acc;
    logic [4:0]  r_count;
    logic [19:0] r_word;
    logic [3:0]  r_pos;
    logic        r_in_msg;
    logic        r_tvalid;
    logic [31:0] r_tdata;
    logic        r_tlast;

    logic [6:0]  rev;
    logic [19:0] acc_eff;
    logic [4:0]  cnt_eff;
    logic [4:0]  total;
    logic        full;
    logic [2:0]  sh;
    logic [26:0] ext;
    logic [26:0] mask;
    logic [19:0] n_acc;
    logic [4:0]  n_count;
    logic [19:0] pad_bits;
    logic [20:0] enc_data;
    logic [31:0] n_tdata;

    // first bit of the character lands highest in the accumulator
    always_comb begin
        for (int i = 0; i < CHAR_BITS; i++) begin
            rev[i] = r_char[CHAR_BITS-1-i];
        end
    end

    assign acc_eff = r_first ? '0 : r_acc;
    assign cnt_eff = r_first ? '0 : r_count;
    assign total   = cnt_eff + 5'd7;
    assign full    = (total >= 5'd20);
    assign sh      = 3'(total - 5'd20);
    assign ext     = {acc_eff, rev};
    assign mask    = (27'd1 << sh) - 27'd1;

    always_comb begin
        if (full) begin
            n_acc   = 20'(ext & mask);
            n_count = {2'b00, sh};
        end else begin
            n_acc   = ext[19:0];
            n_count = total;
        end
    end

    assign pad_bits = r_acc << (5'd20 - r_count);

    always_comb begin
        case (i_cmd.wsel)
            W_ADDR:  enc_data = {1'b0, r_addr[20:3], r_fb};
            W_MSG:   enc_data = {1'b1, r_word};
            default: enc_data = {1'b1, pad_bits};
        endcase
        case (i_cmd.wsel)
            W_PREAMBLE: n_tdata = PREAMBLE_WORD;
            W_SYNC:     n_tdata = SYNC_WORD;
            W_IDLE:     n_tdata = IDLE_WORD;
            default:    n_tdata = f_codeword(enc_data);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw     <= 6'd18;
            r_fb     <= 2'd3;
            r_acc    <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_in_msg <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PREAMBLE: r_pw <= i_cfg_wdata;
                    CFG_FUNCTION: r_fb <= i_cfg_wdata[1:0];
                    default:      r_pw <= r_pw;
                endcase
            end
            if (i_cmd.add) begin
                r_acc   <= n_acc;
                r_count <= n_count;
                if (r_first) begin
                    r_in_msg <= 1'b1;
                end
            end
            if (i_cmd.pos_set) begin
                r_pos <= {r_addr[2:0], 1'b1};
            end else if (i_cmd.pos_inc) begin
                r_pos <= r_pos + 4'd1;
            end
            if (i_cmd.msg_clr) begin
                r_in_msg <= 1'b0;
                r_acc    <= '0;
                r_count  <= '0;
            end
            if (i_cmd.emit) begin
                r_tvalid <= 1'b1;
            end else if (i_out_ready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char  <= i_char_code;
            r_first <= i_first_char;
            r_last  <= i_last_char;
            r_addr  <= i_pager_address;
        end
        if (i_cmd.add && full) begin
            r_word <= 20'(ext >> sh);
        end
        if (i_cmd.emit) begin
            r_tdata <= n_tdata;
            r_tlast <= i_cmd.last_word;
        end
    end

    assign o_stat.first          = r_first;
    assign o_stat.last           = r_last;
    assign o_stat.frame          = r_addr[2:0];
    assign o_stat.in_msg         = r_in_msg;
    assign o_stat.word_full      = full;
    assign o_stat.pad_needed     = (r_count != 5'd0);
    assign o_stat.pos_last       = (r_pos == 4'd15);
    assign o_stat.out_free       = !r_tvalid || i_out_ready;
    assign o_stat.preamble_words = r_pw;

    assign o_out_valid = r_tvalid;
    assign o_codeword  = r_tdata;
    assign o_last_word = r_tlast;

endmodule

@@ hdl/pttx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pttx_ctrl
// Controller: sequences the words of one character, one word per cycle into
// the output register while that register is free.
// ----------------------------------------------------------------------------
module pttx_ctrl
    import pttx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PRE,
        S_SYNC0,
        S_FIDLE,
        S_ADDR,
        S_MSG,
        S_SYNC1,
        S_PAD,
        S_PSYNC,
        S_TAIL
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_state     after_char;
    logic [5:0] r_cnt;
    logic [5:0] n_cnt;
    logic [5:0] wn;
    logic [6:0] room;
    logic [5:0] pre;

    // words that follow the preamble on a first character
    always_comb begin
        if (!i_stat.last) begin
            wn = {2'b00, i_stat.frame, 1'b0} + 6'd2;
        end else if (i_stat.frame == 3'd7) begin
            wn = 6'd34;
        end else begin
            wn = 6'd17;
        end
        room = 7'd64 - {1'b0, wn};
        pre  = ({1'b0, i_stat.preamble_words} > room) ? room[5:0] : i_stat.preamble_words;
    end

    always_comb begin
        if (!i_stat.last) begin
            after_char = S_IDLE;
        end else if (i_stat.pad_needed) begin
            after_char = S_PAD;
        end else begin
            after_char = S_TAIL;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.wsel = W_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_stat.first && !i_stat.in_msg) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.add = 1'b1;
                    if (i_stat.first) begin
                        n_cnt   = pre;
                        n_state = (pre != 6'd0) ? S_PRE : S_SYNC0;
                    end else if (i_stat.word_full) begin
                        n_state = S_MSG;
                    end else if (i_stat.last) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PRE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.wsel = W_PREAMBLE;
                    if (r_cnt == 6'd1) begin
                        n_state = S_SYNC0;
                    end else begin
                        n_cnt = r_cnt - 6'd1;
                    end
                end
            end
            S_SYNC0: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.wsel = W_SYNC;
                    if (i_stat.frame == 3'd0) begin
                        n_state = S_ADDR;
                    end else begin
                        n_cnt   = {2'b00, i_stat.frame, 1'b0};
                        n_state = S_FIDLE;
                    end
                end
            end
            S_FIDLE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.wsel = W_IDLE;
                    if (r_cnt == 6'd1) begin
                        n_state = S_ADDR;
                    end else begin
                        n_cnt = r_cnt - 6'd1;
                    end
                end
            end
            S_ADDR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.wsel    = W_ADDR;
                    o_cmd.pos_set = 1'b1;
                    // a first character never fills a word, so padding follows when it is also the last
                    n_state = i_stat.last ? S_PAD : S_IDLE;
                end
            end
            S_MSG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.wsel    = W_MSG;
                    o_cmd.pos_inc = 1'b1;
                    n_state = i_stat.pos_last ? S_SYNC1 : after_char;
                end
            end
            S_SYNC1: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.wsel = W_SYNC;
                    n_state    = after_char;
                end
            end
            S_PAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.wsel    = W_PAD;
                    o_cmd.pos_inc = 1'b1;
                    n_state = i_stat.pos_last ? S_PSYNC : S_TAIL;
                end
            end
            S_PSYNC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.wsel = W_SYNC;
                    n_state    = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.wsel    = W_IDLE;
                    o_cmd.pos_inc = 1'b1;
                    // idle fill closes the batch
                    if (i_stat.pos_last) begin
                        o_cmd.msg_clr = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.last_word = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hdl/pocsag_text_transmission_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// pocsag_text_transmission_encoder_unit
// Alphanumeric paging encoder with BCH(31,21) plus even parity codewords.
// ----------------------------------------------------------------------------
// One character is taken per input beat; a beat is accepted only while the
// controller is idle, and the words it causes leave through a single output
// register at one word per cycle while the sink is ready. A character can
// produce no word at all, or usually one message word, plus a SYNC after
// every 16th slot. A first character sends the preamble, SYNC, frame IDLE
// words and the address word, and a last character adds any padding and
// IDLE fill to the end of the batch. A character that comes with no open
// page and no first-character flag is dropped. last_word marks the final
// word caused by each input beat.
module pocsag_text_transmission_encoder_unit
    import pttx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // char_code[6:0], pager_address[27:7], zero[31:28]
    input  logic        i_s_axis_tuser,   // first_char[0]
    input  logic        i_s_axis_tlast,   // last_char
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // codeword[31:0]
    output logic        o_m_axis_tlast    // last_word
);

    t_cmd  cmd;
    t_stat stat;

    pttx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pttx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_char_code     (i_s_axis_tdata[6:0]),
        .i_first_char    (i_s_axis_tuser),
        .i_last_char     (i_s_axis_tlast),
        .i_pager_address (i_s_axis_tdata[27:7]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_codeword      (o_m_axis_tdata),
        .o_last_word     (o_m_axis_tlast)
    );

endmodule

@@ hdl/pttx_checker.sv @@
// ----------------------------------------------------------------------------
// pttx_checker
// Port-level checks for the paging encoder, bound to the top level.
// ----------------------------------------------------------------------------
module pttx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // a stalled output beat keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output beat changed while stalled");

    // no new character while words of the current one are still owed
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("input ready before the run of words was complete");

    // an accepted character is decoded before the next one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready straight after an accepted beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind pocsag_text_transmission_encoder_unit pttx_checker u_pttx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
